// ===== src/mul_div_64_wide_intermediate_assert.svh =====
// assertion macros for the wide multiply-divide block
`ifndef MUL_DIV_64_WIDE_INTERMEDIATE_ASSERT_SVH
`define MUL_DIV_64_WIDE_INTERMEDIATE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define MDW_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define MDW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/mdw_pkg.sv =====
// shared types and constants of the wide multiply-divide block
package mdw_pkg;

  localparam int FIELD_W   = 64;
  // partial products of the split multiply
  localparam int MUL_STEPS = 4;

  typedef struct packed {
    logic [FIELD_W-1:0] multiplicand;
    logic [FIELD_W-1:0] multiplier;
    logic [FIELD_W-1:0] divisor;
  } in_t;

  typedef struct packed {
    logic [FIELD_W-1:0] quotient_low;
    logic [FIELD_W-1:0] remainder;
    logic [FIELD_W-1:0] quotient_high;
  } out_t;

endpackage

// ===== src/mul_div_64_wide_intermediate.sv =====
// wide multiply-then-divide: (multiplicand * multiplier) / divisor with double-width quotient
//
//  channel | ports                 | handshake
//  --------+-----------------------+-----------------------------------------
//  input   | start, busy, in_item  | taken at a rising edge with start & !busy
//  result  | out_valid, out_item   | one-cycle strobe, receiver cannot stall
//
// an item keeps the block busy while the product is formed from four half-width
// partial products through one multiplier, then for one restoring divide step per
// quotient bit, then while the result is loaded; a zero divisor skips the product
// and the divide and goes straight to loading the result. out_valid is high in the
// first cycle with busy low. rst_n is synchronous and clears the sequencer and the
// strobe.
module mul_div_64_wide_intermediate #(
  parameter int DATA_WIDTH = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  mdw_pkg::in_t  in_item,
  output logic          out_valid,
  output mdw_pkg::out_t out_item
);
  import mdw_pkg::*;

  localparam int HALF_W = (DATA_WIDTH + 1) / 2;
  localparam int HW2    = 2 * HALF_W;
  localparam int ACC_W  = 4 * HALF_W;
  localparam int DW2    = 2 * DATA_WIDTH;
  localparam int CNT_W  = $clog2(DW2);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  state_t               state_r, state_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 dz_r, dz_nxt;
  logic [HW2-1:0]       a_r, a_nxt;
  logic [HW2-1:0]       b_r, b_nxt;
  logic [DATA_WIDTH-1:0] div_r, div_nxt;
  logic [HW2-1:0]       pp_r, pp_nxt;
  logic [1:0]           pp_idx_r, pp_idx_nxt;
  logic [ACC_W-1:0]     acc_r, acc_nxt;
  logic [DATA_WIDTH-1:0] rem_r, rem_nxt;
  logic [DW2-1:0]       dq_r, dq_nxt;
  out_t                 out_item_r, out_item_nxt;

  logic                  accept;
  logic [HALF_W-1:0]     a_half, b_half;
  logic [ACC_W-1:0]      pp_ext, acc_sum;
  logic [DATA_WIDTH:0]   shifted, diff;
  logic                  ge;

  assign accept = start && (state_r == ST_IDLE);

  // shared half-width multiplier and the accumulate adder
  always_comb begin
    a_half = cnt_r[1] ? a_r[HW2-1:HALF_W] : a_r[HALF_W-1:0];
    b_half = cnt_r[0] ? b_r[HW2-1:HALF_W] : b_r[HALF_W-1:0];
    pp_ext = ACC_W'(pp_r);
    case (pp_idx_r) inside
      2'b00:        acc_sum = acc_r + pp_ext;
      2'b01, 2'b10: acc_sum = acc_r + (pp_ext << HALF_W);
      default:      acc_sum = acc_r + (pp_ext << HW2);
    endcase
  end

  // restoring divide step
  always_comb begin
    shifted = {rem_r, dq_r[DW2-1]};
    diff    = shifted - {1'b0, div_r};
    ge      = (shifted >= {1'b0, div_r});
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = 1'b0;
    dz_nxt        = dz_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    div_nxt       = div_r;
    pp_nxt        = pp_r;
    pp_idx_nxt    = pp_idx_r;
    acc_nxt       = acc_r;
    rem_nxt       = rem_r;
    dq_nxt        = dq_r;
    out_item_nxt  = out_item_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          a_nxt   = HW2'(in_item.multiplicand[DATA_WIDTH-1:0]);
          b_nxt   = HW2'(in_item.multiplier[DATA_WIDTH-1:0]);
          div_nxt = in_item.divisor[DATA_WIDTH-1:0];
          dz_nxt  = (in_item.divisor[DATA_WIDTH-1:0] == '0);
          acc_nxt = '0;
          cnt_nxt = '0;
          state_nxt = (in_item.divisor[DATA_WIDTH-1:0] == '0) ? ST_DONE : ST_MUL;
        end
      end
      ST_MUL: begin
        pp_nxt     = HW2'(a_half * b_half);
        pp_idx_nxt = cnt_r[1:0];
        if (cnt_r != '0) begin
          acc_nxt = acc_sum;
        end
        if (cnt_r == CNT_W'(MUL_STEPS)) begin
          dq_nxt    = acc_sum[DW2-1:0];
          rem_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = ST_DIV;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_DIV: begin
        rem_nxt = ge ? diff[DATA_WIDTH-1:0] : shifted[DATA_WIDTH-1:0];
        dq_nxt  = {dq_r[DW2-2:0], ge};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DW2 - 1)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        out_valid_nxt = 1'b1;
        if (dz_r) begin
          out_item_nxt = '0;
        end else begin
          out_item_nxt.quotient_low  = FIELD_W'(dq_r[DATA_WIDTH-1:0]);
          out_item_nxt.remainder     = FIELD_W'(rem_r);
          out_item_nxt.quotient_high = FIELD_W'(dq_r[DW2-1:DATA_WIDTH]);
        end
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      dz_r        <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      dz_r        <= dz_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    div_r      <= div_nxt;
    pp_r       <= pp_nxt;
    pp_idx_r   <= pp_idx_nxt;
    acc_r      <= acc_nxt;
    rem_r      <= rem_nxt;
    dq_r       <= dq_nxt;
    out_item_r <= out_item_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

`include "mul_div_64_wide_intermediate_assert.svh"

  `MDW_ASSERT_NEXT(a_accept_busy, accept, busy, "accepted item did not raise busy")
  `MDW_ASSERT_NOW(a_strobe_idle, out_valid, !busy, "result strobe while busy")
  `MDW_ASSERT_NEXT(a_strobe_single, out_valid, !out_valid, "result strobe longer than one cycle")
  `MDW_ASSERT_NOW(a_zero_div, out_valid && dz_r, out_item == '0, "zero divisor result not zero")

endmodule
